// ----- hdl/thn_pkg.sv -----
// Shared constants for the tileable hash noise texel pipeline.
package thn_pkg;

  localparam int TILE_SIZE_DEF = 256;
  localparam int OCTAVES_DEF   = 4;
  localparam int OCT_MAX       = 8;

  // Octave persistence 0.55^k held as Q2.30.
  localparam logic [63:0] PERSIST_Q30 [OCT_MAX] = '{
    64'd1073741824, 64'd590558003, 64'd324806902, 64'd178643796,
    64'd98254088,   64'd54039748,  64'd29721862,  64'd16347024
  };

  localparam int WEIGHT_FRAC = 20;
  localparam int WEIGHT_W    = 21;
  localparam int SAMPLE_W    = 16;
  localparam int ACC_W       = 36;
  localparam int SEED_W      = 17;

  localparam logic [31:0] HASH_KX  = 32'd374761;
  localparam logic [31:0] HASH_KY  = 32'd668265;
  localparam logic [31:0] HASH_KS  = 32'd69069;
  localparam logic [31:0] HASH_MUL = 32'd1274126177;

  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_SEED_BASE = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SEED_STEP = 4'd1;

  localparam logic [15:0] SEED_BASE_RST = 16'd1337;
  localparam logic [9:0]  SEED_STEP_RST = 10'd97;

endpackage

// ----- hdl/tileable_hash_noise_texel_top.sv -----
// Pipelined fractal value noise: one texel coordinate in, one 8-bit intensity out.
//
//   channel   signals                                   direction  width
//   command   start, busy, texel_x, texel_y             in (busy out) 1,1,8,8
//   result    done, texel_value                         out        1,8
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data in (ready out) 1,1,4,16
//
// A word enters on every cycle that start is high; busy never rises.
// Each result appears on done/texel_value after passing through
// the eight register stages: coordinates, hash products, xor-shift,
// hash multiply, weighting, octave sum, scaling and final rounding.
// Reset clears the seed registers to their defaults and empties the pipeline.
// The result side cannot stall, so the pipeline always advances.
module tileable_hash_noise_texel_top #(
  parameter int TILE_SIZE = thn_pkg::TILE_SIZE_DEF,
  parameter int OCTAVES   = thn_pkg::OCTAVES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [7:0]                        texel_x,
  input  logic [7:0]                        texel_y,
  output logic                              done,
  output logic [7:0]                        texel_value,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [thn_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [thn_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int OCT = (OCTAVES > thn_pkg::OCT_MAX) ? thn_pkg::OCT_MAX : OCTAVES;
  localparam int CW  = $clog2(TILE_SIZE);
  localparam int PIPE_DEPTH = 8;
  localparam int NW  = 44;
  localparam int MW  = NW - thn_pkg::WEIGHT_FRAC;

  function automatic logic [256*CW-1:0] build_mod_table();
    logic [256*CW-1:0] t;
    t = '0;
    for (int i = 0; i < 256; i++) begin
      t[i*CW +: CW] = CW'(i % TILE_SIZE);
    end
    return t;
  endfunction

  function automatic logic [63:0] persist_sum();
    logic [63:0] s;
    s = '0;
    for (int k = 0; k < OCT; k++) begin
      s = s + thn_pkg::PERSIST_Q30[k];
    end
    return s;
  endfunction

  localparam logic [256*CW-1:0] MOD_TABLE = build_mod_table();
  localparam logic [63:0] PSUM = persist_sum();

  function automatic logic [63:0] weight_sum();
    logic [63:0] s;
    s = '0;
    for (int k = 0; k < OCT; k++) begin
      s = s + ((thn_pkg::PERSIST_Q30[k] << thn_pkg::WEIGHT_FRAC) + PSUM / 2) / PSUM;
    end
    return s;
  endfunction

  localparam logic [63:0] WSUM    = weight_sum();
  localparam logic [63:0] ACC_MAX = 64'd65535 * WSUM;
  localparam logic [NW-1:0] HALF_DEN = NW'(64'd65535 << (thn_pkg::WEIGHT_FRAC - 1));

  // Configuration registers.
  logic [15:0] seed_base;
  logic [9:0]  seed_step;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_base <= thn_pkg::SEED_BASE_RST;
      seed_step <= thn_pkg::SEED_STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        thn_pkg::REG_SEED_BASE: seed_base <= cfg_data;
        thn_pkg::REG_SEED_STEP: seed_step <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  logic [PIPE_DEPTH-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PIPE_DEPTH-2:0], start && !busy};
    end
  end

  assign done = vld[PIPE_DEPTH-1];

  // Stage 1: per-octave sample coordinates and seeds.
  logic [CW-1:0] sx_chain [OCT];
  logic [CW-1:0] sy_chain [OCT];
  logic [CW:0]   dx [OCT];
  logic [CW:0]   dy [OCT];

  // Doubling modulo the tile size keeps each step to one compare and subtract.
  always_comb begin
    sx_chain[0] = MOD_TABLE[texel_x*CW +: CW];
    sy_chain[0] = MOD_TABLE[texel_y*CW +: CW];
    dx[0] = '0;
    dy[0] = '0;
    for (int o = 1; o < OCT; o++) begin
      dx[o] = {sx_chain[o-1], 1'b0};
      dy[o] = {sy_chain[o-1], 1'b0};
      sx_chain[o] = (dx[o] >= (CW+1)'(TILE_SIZE)) ? CW'(dx[o] - (CW+1)'(TILE_SIZE)) : CW'(dx[o]);
      sy_chain[o] = (dy[o] >= (CW+1)'(TILE_SIZE)) ? CW'(dy[o] - (CW+1)'(TILE_SIZE)) : CW'(dy[o]);
    end
  end

  logic [CW-1:0]                 sx1   [OCT];
  logic [CW-1:0]                 sy1   [OCT];
  logic [thn_pkg::SEED_W-1:0]    seed1 [OCT];
  logic [31:0]                   px2   [OCT];
  logic [31:0]                   py2   [OCT];
  logic [31:0]                   ps2   [OCT];
  logic [31:0]                   h3    [OCT];
  logic [15:0]                   h4    [OCT];
  logic [thn_pkg::ACC_W-1:0]     wv5   [OCT];
  logic [thn_pkg::WEIGHT_W-1:0]  weight [OCT];
  logic [thn_pkg::ACC_W-1:0]     acc6;
  logic [thn_pkg::ACC_W-1:0]     acc_sum;
  logic [MW-1:0]                 m7;
  logic [NW-1:0]                 scaled;

  for (genvar o = 0; o < OCT; o++) begin : g_octave
    localparam logic [63:0] W64 =
      ((thn_pkg::PERSIST_Q30[o] << thn_pkg::WEIGHT_FRAC) + PSUM / 2) / PSUM;

    logic [31:0] h_lin;
    logic [31:0] h_mul;
    logic [15:0] sample;

    assign weight[o] = thn_pkg::WEIGHT_W'(W64);
    assign h_lin  = px2[o] + py2[o] + ps2[o];
    assign h_mul  = 32'(h3[o] * thn_pkg::HASH_MUL);
    assign sample = h4[o];

    always_ff @(posedge clk) begin
      sx1[o]   <= sx_chain[o];
      sy1[o]   <= sy_chain[o];
      seed1[o] <= thn_pkg::SEED_W'(seed_base)
                + thn_pkg::SEED_W'(seed_step) * thn_pkg::SEED_W'(o);
      px2[o]   <= 32'(32'(sx1[o]) * thn_pkg::HASH_KX);
      py2[o]   <= 32'(32'(sy1[o]) * thn_pkg::HASH_KY);
      ps2[o]   <= 32'(32'(seed1[o]) * thn_pkg::HASH_KS);
      h3[o]    <= h_lin ^ (h_lin >> 13);
      // The sample is the low half of the hash product xor-folded with its high half.
      h4[o]    <= h_mul[15:0] ^ h_mul[31:16];
      wv5[o]   <= thn_pkg::ACC_W'(weight[o]) * thn_pkg::ACC_W'(sample);
    end
  end

  always_comb begin
    acc_sum = '0;
    for (int o = 0; o < OCT; o++) begin
      acc_sum = acc_sum + wv5[o];
    end
  end

  assign scaled = NW'(acc6) * NW'(255) + HALF_DEN;

  // Final stage: divide by 65535 as shift plus one remainder correction.
  logic [7:0]  q0;
  logic [16:0] rem;
  logic        rem_ge;
  logic [16:0] rem_fix;
  logic [8:0]  quot;

  always_comb begin
    q0      = m7[MW-1:16];
    rem     = {1'b0, m7[15:0]} + 17'(q0);
    rem_ge  = rem >= 17'd65535;
    rem_fix = rem_ge ? rem - 17'd65535 : rem;
    quot    = {1'b0, q0} + {8'd0, rem_ge};
  end

  always_ff @(posedge clk) begin
    acc6        <= acc_sum;
    m7          <= scaled[NW-1:thn_pkg::WEIGHT_FRAC];
    texel_value <= (quot > 9'd255) ? 8'd255 : quot[7:0];
  end

`ifndef SYNTHESIS
  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, PIPE_DEPTH))
    else $error("result word without a matching command word");

  a_acc_bound: assert property (@(posedge clk) disable iff (rst)
    vld[5] |-> (64'(acc6) <= ACC_MAX))
    else $error("octave sum exceeds the weighted maximum");

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    vld[6] |-> (rem_fix < 17'd65535))
    else $error("scaling remainder out of range after correction");
`endif

endmodule
